// ===== rtl/ths_pkg.sv =====
package ths_pkg;

    // item codes carried in s_tuser
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // field widths of the stream items
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int RIGHT_W  = 11;
    localparam int LENGTH_W = 11;

    // input tdata layout, lowest bit first
    localparam int S_IDX_LSB   = 0;
    localparam int S_VAL_LSB   = S_IDX_LSB + INDEX_W;
    localparam int S_KEY_LSB   = S_VAL_LSB + VALUE_W;
    localparam int S_GUESS_LSB = S_KEY_LSB + VALUE_W;
    localparam int S_FIELDS_W  = S_GUESS_LSB + INDEX_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int M_FOUND_LSB = 0;
    localparam int M_RIGHT_LSB = M_FOUND_LSB + INDEX_W;
    localparam int M_FIELDS_W  = M_RIGHT_LSB + RIGHT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // tables shorter than this return index zero below the last entry
    localparam int SHORT_LEN = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_PROBE,
        ST_UP,
        ST_DOWN,
        ST_BIS,
        ST_DONE
    } ths_state_t;

    typedef struct packed {
        logic [INDEX_W-1:0] found_index;
        logic [RIGHT_W-1:0] right_index;
        logic               empty_error;
    } ths_res_t;

endpackage

// ===== rtl/ths_table_mem.sv =====
module ths_table_mem
    import ths_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ths_hunt.sv =====
module ths_hunt
    import ths_pkg::*;
#(
    parameter int IDX_W    = 10,
    parameter int LEN_W    = 11,
    parameter int KEY_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                is_search,
    input  logic [KEY_BITS-1:0] key,
    input  logic [INDEX_W-1:0]  guess,
    input  logic [LEN_W-1:0]    len,
    output logic                ready,
    output logic [IDX_W-1:0]    rd_addr,
    input  logic [KEY_BITS-1:0] rd_data,
    output logic                res_valid,
    output ths_res_t            res,
    input  logic                res_take
);

    // arithmetic width: index plus room for a doubled step
    localparam int AW = IDX_W + 2;
    localparam int GW = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    ths_state_t state_reg, state_next;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] last_val_reg, last_val_next;
    logic                ascend_reg, ascend_next;
    logic                short_reg, short_next;
    logic [INDEX_W-1:0]  guess_reg, guess_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic [IDX_W-1:0]    mid_reg, mid_next;
    logic [AW-1:0]       step_reg, step_next;
    logic [IDX_W-1:0]    found_reg, found_next;
    logic                err_reg, err_next;
    logic                hit_reg, hit_next;

    logic                past;
    logic                launch;
    logic [IDX_W-1:0]    l_sel;
    logic [IDX_W-1:0]    h_sel;
    logic [AW-1:0]       step_dbl;
    logic [AW-1:0]       hi_try;
    logic [AW-1:0]       lo_ext;
    logic [AW-1:0]       span;
    logic [AW-1:0]       mid_sum;

    // key on the at-or-past side of the entry just read
    assign past = ($signed(key_reg) >= $signed(rd_data)) == ascend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        last_val_reg <= last_val_next;
        ascend_reg   <= ascend_next;
        short_reg    <= short_next;
        guess_reg    <= guess_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        step_reg     <= step_next;
        found_reg    <= found_next;
        err_reg      <= err_next;
        hit_reg      <= hit_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        last_val_next = last_val_reg;
        ascend_next   = ascend_reg;
        short_next    = short_reg;
        guess_next    = guess_reg;
        last_next     = last_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        err_next      = err_reg;
        hit_next      = hit_reg;
        ready         = 1'b0;
        res_valid     = 1'b0;
        rd_addr       = '0;
        launch        = 1'b0;
        l_sel         = lo_reg;
        h_sel         = hi_reg;
        step_dbl      = step_reg << 1;
        hi_try        = '0;
        lo_ext        = '0;
        span          = '0;
        mid_sum       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                rd_addr = IDX_W'(len - LEN_W'(1));
                if (start)
                begin
                    found_next = '0;
                    err_next   = 1'b0;
                    hit_next   = 1'b0;
                    if (!is_search)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (len == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        hit_next   = 1'b1;
                        key_next   = key;
                        guess_next = guess;
                        last_next  = IDX_W'(len - LEN_W'(1));
                        short_next = (len < LEN_W'(SHORT_LEN));
                        state_next = ST_RD_LAST;
                    end
                end
            end

            ST_RD_LAST:
            begin
                if ($signed(key_reg) >= $signed(rd_data))
                begin
                    found_next = last_reg;
                    state_next = ST_DONE;
                end
                else if (short_reg)
                begin
                    found_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    last_val_next = rd_data;
                    rd_addr       = '0;
                    state_next    = ST_RD_FIRST;
                end
            end

            ST_RD_FIRST:
            begin
                // rd_data holds the first entry here
                ascend_next = $signed(last_val_reg) >= $signed(rd_data);
                if (GW'(guess_reg) < GW'(last_reg))
                begin
                    lo_next = IDX_W'(guess_reg);
                end
                else
                begin
                    lo_next = last_reg;
                end
                rd_addr    = lo_next;
                step_next  = AW'(1);
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                lo_ext = AW'(lo_reg);
                if (past)
                begin
                    hi_try = lo_ext + step_reg;
                    if (hi_try >= AW'(last_reg))
                    begin
                        launch = 1'b1;
                        l_sel  = lo_reg;
                        h_sel  = last_reg;
                    end
                    else
                    begin
                        hi_next    = IDX_W'(hi_try);
                        rd_addr    = IDX_W'(hi_try);
                        state_next = ST_UP;
                    end
                end
                else if (lo_ext <= step_reg)
                begin
                    launch = 1'b1;
                    l_sel  = '0;
                    h_sel  = lo_reg;
                end
                else
                begin
                    hi_next    = lo_reg;
                    lo_next    = IDX_W'(lo_ext - step_reg);
                    rd_addr    = IDX_W'(lo_ext - step_reg);
                    state_next = ST_DOWN;
                end
            end

            ST_UP:
            begin
                // rd_data holds entry hi
                hi_try = AW'(hi_reg) + step_dbl;
                if (!past)
                begin
                    launch = 1'b1;
                end
                else if (hi_try >= AW'(last_reg))
                begin
                    launch = 1'b1;
                    l_sel  = hi_reg;
                    h_sel  = last_reg;
                end
                else
                begin
                    lo_next   = hi_reg;
                    hi_next   = IDX_W'(hi_try);
                    step_next = step_dbl;
                    rd_addr   = IDX_W'(hi_try);
                end
            end

            ST_DOWN:
            begin
                // rd_data holds entry lo
                lo_ext = AW'(lo_reg);
                if (past)
                begin
                    launch = 1'b1;
                end
                else if (lo_ext <= step_dbl)
                begin
                    launch = 1'b1;
                    l_sel  = '0;
                    h_sel  = lo_reg;
                end
                else
                begin
                    hi_next   = lo_reg;
                    lo_next   = IDX_W'(lo_ext - step_dbl);
                    step_next = step_dbl;
                    rd_addr   = IDX_W'(lo_ext - step_dbl);
                end
            end

            ST_BIS:
            begin
                // rd_data holds entry mid
                launch = 1'b1;
                if (past)
                begin
                    l_sel = mid_reg;
                end
                else
                begin
                    h_sel = mid_reg;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // next bisection probe, or finish once the bracket is at most one wide
        if (launch)
        begin
            lo_next = l_sel;
            hi_next = h_sel;
            span    = AW'(h_sel) - AW'(l_sel);
            mid_sum = AW'(h_sel) + AW'(l_sel);
            if (span > AW'(1))
            begin
                mid_next   = IDX_W'(mid_sum >> 1);
                rd_addr    = IDX_W'(mid_sum >> 1);
                state_next = ST_BIS;
            end
            else
            begin
                found_next = l_sel;
                state_next = ST_DONE;
            end
        end
    end

    // writes and empty-table searches report zero in both index fields
    assign res.found_index = INDEX_W'(found_reg);
    assign res.right_index = hit_reg ? RIGHT_W'(AW'(found_reg) + AW'(1)) : '0;
    assign res.empty_error = err_reg;

endmodule

// ===== rtl/table_hunt_search.sv =====
// channel  | dir | payload (lowest bit first)                               | handshake
// ---------+-----+----------------------------------------------------------+-------------------
// s_*      | in  | tdata: entry_index, entry_value, search_key, start_guess | s_tvalid/s_tready
//          |     | tuser: action (0 write entry, 1 search)                  |
// m_*      | out | tdata: found_index, right_index; tuser: empty_error      | m_tvalid/m_tready
// cfg_*    | in  | cfg_data: table_length                                   | cfg_valid/cfg_ready
//
// one item is worked at a time; a write or a search on an empty table reads no entry, a search
// ending at the last entry or on a short table reads only the last entry, any other search reads
// the last, first and guess entries, then one entry per gallop and per bisection step
// each read waits on the registered output of the single table memory port
// rst_n clears control state and table_length; table contents stay undefined
// a result waiting in the output register does not block the next item; a second result
// holds the engine in its done state until the register drains
module table_hunt_search
    import ths_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index[9:0], entry_value[41:10], search_key[73:42], start_guess[83:74]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found_index[9:0], right_index[20:10]
    output logic [M_TDATA_W-1:0] m_tdata,
    // empty_error[0]
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LENGTH_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W = IDX_W + 1;
    localparam int CW    = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
    localparam int WW    = (IDX_W + 1 > INDEX_W) ? IDX_W + 1 : INDEX_W;
    localparam int KB_IN = (KEY_BITS < VALUE_W) ? KEY_BITS : VALUE_W;

    logic [LENGTH_W-1:0] table_length_reg;
    logic [LEN_W-1:0]    len_eff;

    logic                s_accept;
    logic [INDEX_W-1:0]  entry_index;
    logic [VALUE_W-1:0]  entry_value;
    logic [VALUE_W-1:0]  search_key;
    logic [INDEX_W-1:0]  start_guess;
    logic [KEY_BITS-1:0] value_key;
    logic [KEY_BITS-1:0] search_k;
    logic                mem_we;

    logic [IDX_W-1:0]    rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic                hunt_ready;
    logic                res_valid;
    logic                res_take;
    ths_res_t            res;

    logic                m_valid_reg;
    ths_res_t            m_res_reg;

    // field unpack
    assign entry_index = s_tdata[S_IDX_LSB +: INDEX_W];
    assign entry_value = s_tdata[S_VAL_LSB +: VALUE_W];
    assign search_key  = s_tdata[S_KEY_LSB +: VALUE_W];
    assign start_guess = s_tdata[S_GUESS_LSB +: INDEX_W];

    // keys keep their low KEY_BITS bits, or are zero extended when wider
    assign value_key = KEY_BITS'(entry_value[KB_IN-1:0]);
    assign search_k  = KEY_BITS'(search_key[KB_IN-1:0]);

    assign s_tready = hunt_ready;
    assign s_accept = s_tvalid && s_tready;

    // writes past the table depth are dropped
    assign mem_we = s_accept && (s_tuser == ACT_WRITE)
                    && (WW'(entry_index) < WW'(TABLE_DEPTH));

    // length register, saturated to the table depth on use
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            table_length_reg <= cfg_data;
        end
    end

    assign len_eff = (CW'(table_length_reg) > CW'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                                : LEN_W'(table_length_reg);

    ths_table_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (KEY_BITS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IDX_W'(entry_index)),
        .wdata (value_key),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ths_hunt #(
        .IDX_W    (IDX_W),
        .LEN_W    (LEN_W),
        .KEY_BITS (KEY_BITS)
    ) u_hunt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_accept),
        .is_search (s_tuser == ACT_SEARCH),
        .key       (search_k),
        .guess     (start_guess),
        .len       (len_eff),
        .ready     (hunt_ready),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // output register: loads whenever it is empty or being drained
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_res_reg.right_index, m_res_reg.found_index});
    assign m_tuser  = m_res_reg.empty_error;

endmodule

// ===== tb/table_hunt_search_test.sv =====
module table_hunt_search_test;
    import ths_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;

    // random traffic: each side stalls about 17 percent of the time while gaps are on
    localparam int IDLE_PCT = 17;
    // within every CALM_PERIOD window the stretch from CALM_START on runs without gaps
    localparam int CALM_PERIOD = 4000;
    localparam int CALM_START  = 2500;

    // settle time after a drain, well past the longest search
    localparam int SETTLE_CYCLES  = 32;
    // cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;

    // size of the random part, counted in items
    localparam int RANDOM_ITEMS = 680;

    localparam longint KEY_MIN = -64'sd2147483648;
    localparam longint KEY_MAX = 64'sd2147483647;

    // table layouts used for random rounds
    typedef enum logic [1:0] {
        SHAPE_RISE,
        SHAPE_FALL,
        SHAPE_FLAT,
        SHAPE_NOISE
    } shape_t;

    // one stream item before packing; guess sits in the top field of tdata
    typedef struct packed {
        logic               act;
        logic [INDEX_W-1:0] guess;
        logic [VALUE_W-1:0] key;
        logic [VALUE_W-1:0] val;
        logic [INDEX_W-1:0] idx;
    } job_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LENGTH_W-1:0]  cfg_data  = '0;

    // items waiting to be driven, filled ahead by the sequence below
    job_t        outgoing_items[$];
    // bracket results predicted for accepted items, oldest first
    ths_res_t    expected_brackets[$];

    // predictor state, advanced only by accepted items and length writes
    logic signed [VALUE_W-1:0] stored_keys[TABLE_DEPTH];
    int unsigned               active_len;

    // what the sequence believes the table holds, used to aim search keys
    logic [VALUE_W-1:0] plan_keys[TABLE_DEPTH];
    int unsigned        plan_len;

    int unsigned cyc;
    int unsigned quiet;
    logic        gaps_on;
    int          errors;
    int          n_writes;
    int          n_searches;
    int          n_empty;
    int          n_settings;

    assign gaps_on = (cyc % CALM_PERIOD) < CALM_START;

    table_hunt_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // key lies at or past entry idx in the direction the table runs
    function automatic logic on_far_side(logic signed [VALUE_W-1:0] key, int unsigned idx,
                                         logic ascend);
        return (key >= stored_keys[idx]) == ascend;
    endfunction

    // gallop out from the guess with doubling steps, then bisect the bracket
    function automatic int unsigned hunt_bracket(logic signed [VALUE_W-1:0] key,
                                                 int unsigned len, int unsigned guess);
        int unsigned last;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned step;
        logic        ascend;
        logic        galloping;
        last = len - 1;
        // key at or above the last entry
        if (stored_keys[last] <= key)
            return last;
        // too short to hunt in
        if (len < SHORT_LEN)
            return 0;
        lo        = (guess < last) ? guess : last;
        hi        = lo;
        step      = 1;
        galloping = 1'b1;
        ascend    = stored_keys[last] >= stored_keys[0];
        if (on_far_side(key, lo, ascend))
        begin
            // walk toward the last entry
            while (galloping)
            begin
                hi = lo + step;
                if (hi >= last)
                begin
                    hi        = last;
                    galloping = 1'b0;
                end
                else if (!on_far_side(key, hi, ascend))
                    galloping = 1'b0;
                else
                begin
                    lo   = hi;
                    step = step + step;
                end
            end
        end
        else
        begin
            // walk toward entry zero
            while (galloping)
            begin
                if (lo <= step)
                begin
                    lo        = 0;
                    galloping = 1'b0;
                end
                else
                begin
                    lo = lo - step;
                    if (on_far_side(key, lo, ascend))
                        galloping = 1'b0;
                    else
                    begin
                        hi   = lo;
                        step = step + step;
                    end
                end
            end
        end
        while (hi - lo > 1)
        begin
            mid = (hi + lo) >> 1;
            if (on_far_side(key, mid, ascend))
                lo = mid;
            else
                hi = mid;
        end
        return (lo < last) ? lo : last;
    endfunction

    // apply one accepted item to the table copy and give its result
    function automatic ths_res_t predict_bracket(logic act, logic [S_TDATA_W-1:0] d);
        ths_res_t    r;
        int unsigned len;
        int unsigned pos;
        r = '0;
        if (act == ACT_WRITE)
        begin
            stored_keys[d[S_IDX_LSB +: INDEX_W]] = d[S_VAL_LSB +: VALUE_W];
            return r;
        end
        // lengths past the table depth saturate
        len = (active_len < TABLE_DEPTH) ? active_len : TABLE_DEPTH;
        if (len == 0)
        begin
            r.empty_error = 1'b1;
            return r;
        end
        pos           = hunt_bracket(d[S_KEY_LSB +: VALUE_W], len, d[S_GUESS_LSB +: INDEX_W]);
        r.found_index = pos[INDEX_W-1:0];
        r.right_index = RIGHT_W'(pos + 1);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: one item per handshake, random gaps between items
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        job_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (outgoing_items.size() != 0
                && !(gaps_on && $urandom_range(0, 99) < IDLE_PCT))
            begin
                nxt = outgoing_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.act;
                // index, value, key, guess from bit 0 up, zero fill on top
                s_tdata  <= S_TDATA_W'({nxt.guess, nxt.key, nxt.val, nxt.idx});
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // monitor: check results first, then predict the item taken this edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ths_res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (m_tuser)
                    n_empty++;
                if (expected_brackets.size() == 0)
                begin
                    $error("result item with nothing expected: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = expected_brackets.pop_front();
                    if (m_tdata[M_FOUND_LSB +: INDEX_W] !== want.found_index)
                    begin
                        $error("found_index expected %0d actual %0d",
                               want.found_index, m_tdata[M_FOUND_LSB +: INDEX_W]);
                        errors++;
                    end
                    if (m_tdata[M_RIGHT_LSB +: RIGHT_W] !== want.right_index)
                    begin
                        $error("right_index expected %0d actual %0d",
                               want.right_index, m_tdata[M_RIGHT_LSB +: RIGHT_W]);
                        errors++;
                    end
                    if (m_tuser !== want.empty_error)
                    begin
                        $error("empty_error expected %0d actual %0d",
                               want.empty_error, m_tuser);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                active_len = cfg_data;
                n_settings++;
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_WRITE)
                    n_writes++;
                else
                    n_searches++;
                expected_brackets.push_back(predict_bracket(s_tuser, s_tdata));
            end
        end
    end

    // watchdog: any handshake counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc <= cyc + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------

    // table write; the search fields ride along with random content
    task automatic queue_write(int unsigned idx, logic [VALUE_W-1:0] val);
        job_t j;
        j.act   = ACT_WRITE;
        j.idx   = INDEX_W'(idx);
        j.val   = val;
        j.key   = $urandom;
        j.guess = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        outgoing_items.push_back(j);
        plan_keys[idx] = val;
    endtask

    // search; the write fields ride along with random content
    task automatic queue_search(logic [VALUE_W-1:0] key, logic [INDEX_W-1:0] guess);
        job_t j;
        j.act   = ACT_SEARCH;
        j.idx   = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        j.val   = $urandom;
        j.key   = key;
        j.guess = guess;
        outgoing_items.push_back(j);
    endtask

    // search aimed at the table: hits, near misses, outliers; guesses near or far
    task automatic queue_probe();
        int unsigned        r;
        int unsigned        pick;
        logic [VALUE_W-1:0] key;
        logic [INDEX_W-1:0] guess;
        r    = (plan_len == 0) ? 0 : $urandom_range(0, plan_len - 1);
        pick = $urandom_range(0, 9);
        if (plan_len == 0 || pick == 7)
            key = $urandom;
        else if (pick <= 3)
            key = plan_keys[r];
        else if (pick <= 5)
            key = plan_keys[r] + 1;
        else if (pick == 6)
            key = plan_keys[r] - 1;
        else if (pick == 8)
            key = 32'h8000_0000;
        else
            key = 32'h7fff_ffff;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            guess = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        else if (pick == 4)
            guess = '0;
        else if (pick == 5)
            guess = '1;
        else
            guess = INDEX_W'(r + $urandom_range(0, 16) - 8);
        queue_search(key, guess);
    endtask

    // fill entries 0 to len-1 with a table of the given layout
    task automatic load_table(int unsigned len, shape_t shape);
        longint      v;
        int unsigned cap;
        int unsigned i;
        int unsigned pick;
        pick = $urandom_range(0, 4);
        cap  = (pick == 0) ? 1 : (pick == 1) ? 3 : (pick == 2) ? 65536 :
               (pick == 3) ? (1 << 22) : (1 << 28);
        // sometimes start right at the bottom of the key range
        v = ($urandom_range(0, 7) == 0) ? KEY_MIN : longint'($signed($urandom));
        for (i = 0; i < len; i++)
        begin
            if (shape == SHAPE_NOISE)
                v = longint'($signed($urandom));
            if (shape == SHAPE_FALL)
                queue_write(len - 1 - i, v[VALUE_W-1:0]);
            else
                queue_write(i, v[VALUE_W-1:0]);
            // plateaus now and then, saturating at the top of the range
            if (shape != SHAPE_FLAT && $urandom_range(0, 3) != 0)
                v = v + $urandom_range(0, cap);
            if (v > KEY_MAX)
                v = KEY_MAX;
        end
    endtask

    // block idle: nothing queued, nothing in flight, nothing expected
    task automatic wait_drained();
        do
            @(negedge clk);
        while (outgoing_items.size() != 0 || s_tvalid || expected_brackets.size() != 0);
    endtask

    // length write, only once the block has gone idle
    task automatic set_length(int unsigned len);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= LENGTH_W'(len);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        plan_len = (len < TABLE_DEPTH) ? len : TABLE_DEPTH;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned made;
        int unsigned len;
        int unsigned pick;
        int unsigned probes;
        int unsigned k;
        shape_t      shape;

        plan_len = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty table after reset, both key extremes
        queue_search(32'h8000_0000, 10'd0);
        queue_search(32'h7fff_ffff, 10'h3ff);

        // short ascending table spanning the key range, plus the top slot
        queue_write(0, 32'h8000_0000);
        queue_write(1, 32'hffff_0000);
        queue_write(2, 32'h0000_0000);
        queue_write(3, 32'h0000_0001);
        queue_write(4, 32'h0001_0000);
        queue_write(5, 32'h0010_0000);
        queue_write(6, 32'h7fff_0000);
        queue_write(7, 32'h7fff_ffff);
        queue_write(1023, 32'h5555_aaaa);

        // single entry: key equal to it, key above it
        set_length(1);
        queue_search(32'h8000_0000, 10'd0);
        queue_search(32'h7fff_ffff, 10'h3ff);

        // two entries: key at last, key below last on a short table
        set_length(2);
        queue_search(32'hffff_0000, 10'd1);
        queue_search(32'h8000_0000, 10'd0);

        // eight entries: at last, gallop down to zero, gallop up, exact hits, between
        set_length(8);
        queue_search(32'h7fff_ffff, 10'h3ff);
        queue_search(32'h8000_0000, 10'h3ff);
        queue_search(32'h0000_0000, 10'd0);
        queue_search(32'h0001_0000, 10'd3);
        queue_search(32'h7fff_0000, 10'd1);
        queue_search(32'h0008_0000, 10'd6);

        // full depth, then lengths past the depth that saturate; keys sit at or
        // above the top slot so only that entry is looked at
        set_length(TABLE_DEPTH);
        queue_search(32'h7fff_ffff, 10'd0);
        queue_search(32'h5555_aaaa, 10'd512);
        set_length(2047);
        queue_search(32'h5555_aaab, 10'h3ff);
        queue_search(32'h7fff_ffff, 10'd7);
        set_length(1500);
        queue_search(32'h5555_aaaa, 10'd3);

        // random rounds: mostly small monotone tables, some noise and stray writes
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = 0;
            else if (pick == 1)
                len = $urandom_range(1, 2);
            else if (pick == 2)
                len = $urandom_range(100, 300);
            else
                len = $urandom_range(3, 48);
            pick = $urandom_range(0, 9);
            shape = (pick == 0) ? SHAPE_FLAT : (pick == 1) ? SHAPE_NOISE :
                    (pick <= 5) ? SHAPE_RISE : SHAPE_FALL;
            set_length(len);
            load_table(len, shape);
            probes = $urandom_range(10, 30);
            for (k = 0; k < probes; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                    queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
                else
                    queue_probe();
            end
            made += len + probes;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_brackets.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_brackets.size());
            errors++;
        end

        $display("covered %0d searches (%0d on an empty table) and %0d entry writes",
                 n_searches, n_empty, n_writes);
        $display("over %0d table length settings, %0d mismatches", n_settings, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ths_pkg.sv
rtl/ths_table_mem.sv
rtl/ths_hunt.sv
rtl/table_hunt_search.sv
tb/table_hunt_search_test.sv
